/* hw/rtl/assert_macros.svh */
// Assertion macros used by the trainer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/lrgd_pkg.sv */
// Types, codes and arithmetic helpers for the gradient descent trainer.
package lrgd_pkg;

  localparam int MAX_FEATURES = 8;
  localparam int MAX_SAMPLES  = 256;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DIVIDEND_W = 64;
  localparam int NS_W       = $clog2(MAX_SAMPLES + 1);
  localparam int DIVISOR_W  = NS_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_THRESHOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FEATURES_IN_USE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_IN_USE  = 3'd4;

  localparam logic [1:0] CMD_LOAD_FEATURE = 2'd0;
  localparam logic [1:0] CMD_LOAD_TARGET  = 2'd1;
  localparam logic [1:0] CMD_TRAIN        = 2'd2;
  localparam logic [1:0] CMD_PREDICT      = 2'd3;

  localparam logic [1:0] STATUS_TRAIN_DONE  = 2'd0;
  localparam logic [1:0] STATUS_PRED_READY  = 2'd1;
  localparam logic [1:0] STATUS_NOT_TRAINED = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_P_MUL, S_P_ACC,
    S_T_PASS, S_T_SAMP, S_T_PRD, S_T_PMUL, S_T_PACC, S_T_ERR,
    S_T_GRD, S_T_GMUL, S_T_GACC, S_T_SQ, S_T_LOSS,
    S_T_CUR, S_T_CURW, S_T_DIFF, S_T_CMP1, S_T_CMP2, S_T_CMP3, S_T_CMP4,
    S_T_UDIV, S_T_UWAIT, S_T_UM1, S_T_UM2, S_T_UUPD, S_T_FIN,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63]))
      sat_add64 = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else
      sat_add64 = s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sh0_7FFF_FFFF)
      sat32 = 32'sh7FFF_FFFF;
    else if (v < -65'sh0_8000_0000)
      sat32 = 32'sh8000_0000;
    else
      sat32 = v[31:0];
  endfunction

endpackage

/* hw/rtl/linear_regression_gd_trainer_unit.sv */
// Top level of the fixed-point batch gradient descent linear regression trainer.
// A word on the input channel is a command. Load-feature and load-target words
// write the feature and target memories and do not stall the input; they give no
// result. A predict word on a trained model holds the input through a multiply
// and an accumulate state, and an output state for the last feature in use: one
// shared 33x33 multiplier forms weight*feature and the sum is kept with
// saturation; the word for the last feature in use gives one result (prediction
// ready, or not trained). A train word runs up to iteration_limit passes and
// gives one result with the stop iteration. Each pass walks every sample twice
// over its features through the shared multiplier, then divides the loss and
// each gradient sum in a 64-step bit-serial divider. The block takes no new
// word while it works on one, but a finished result may wait in the output
// register while the next word is accepted. Configuration writes are taken at
// any time and must only happen while the block is idle. Weights and bias
// persist between trainings; memories are not cleared by reset.
`include "assert_macros.svh"
module linear_regression_gd_trainer_unit import lrgd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_cmd,
  input  logic [7:0]            in_sample_index,
  input  logic [2:0]            in_feature_index,
  input  logic signed [31:0]    in_sample_value,
  // result words
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic signed [31:0]    out_prediction,
  output logic [15:0]           out_stop_iteration,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NFW = $clog2(MAX_FEATURES + 1);
  localparam int FW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int TAW = $clog2(MAX_SAMPLES);
  localparam int AW  = $clog2(MAX_SAMPLES * MAX_FEATURES);
  localparam int FDEPTH = MAX_SAMPLES * MAX_FEATURES;

  // configuration registers
  logic [15:0] rate_r, iter_lim_r, thr_r;
  logic [3:0]  feat_use_r;
  logic [8:0]  samp_use_r;

  // sequencer and datapath
  state_t state_r, state_nxt;
  logic signed [31:0] w_r [MAX_FEATURES];
  logic signed [63:0] grad_r [MAX_FEATURES];
  logic signed [31:0] bias_r;
  logic signed [63:0] bgrad_r;
  logic [63:0]        loss_r, prev_r, curr_r, diff_r;
  logic               trained_r;
  logic signed [63:0] psum_r;
  logic signed [63:0] yp_r;
  logic signed [31:0] err_r;
  logic signed [63:0] prod_r;
  logic signed [63:0] aux_r;
  logic [79:0]        rhs_r;
  logic signed [47:0] g_r;
  logic [NS_W-1:0]    scnt_r;
  logic [NFW-1:0]     jcnt_r;
  logic [15:0]        it_r;
  logic [FW-1:0]      p_fi_r;
  logic signed [31:0] p_val_r;
  logic [1:0]         pend_status_r;
  logic signed [31:0] pend_pred_r;
  logic [15:0]        pend_stop_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic signed [31:0] out_prediction_r;
  logic [15:0]        out_stop_iteration_r;

  // memories
  logic signed [31:0] fmem [FDEPTH];
  logic signed [31:0] tmem [MAX_SAMPLES];
  logic signed [31:0] fdat_r, tdat_r;
  logic [AW-1:0]      fwaddr, fraddr;
  logic               fmem_we, tmem_we;

  // comb signals
  logic [NFW-1:0]     nf;
  logic [NS_W-1:0]    ns;
  logic               in_acc;
  logic [FW-1:0]      widx, jidx;
  logic signed [31:0] w_rd;
  logic signed [63:0] gsel;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;
  logic signed [63:0] prod_sh;
  logic signed [63:0] psum_nxt;
  logic signed [31:0] cur_val, upd_val;
  logic signed [63:0] upd_total, upd_step;
  logic signed [47:0] g_sat;
  logic               stop_hit;
  logic               fi_in_range, fi_last;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // clamp the feature and sample counts to what the stores hold, with at least one feature and two samples
  always_comb begin
    if (feat_use_r == 4'd0)
      nf = NFW'(1);
    else if (32'(feat_use_r) > MAX_FEATURES)
      nf = NFW'(MAX_FEATURES);
    else
      nf = NFW'(feat_use_r);
    if (32'(samp_use_r) > MAX_SAMPLES)
      ns = NS_W'(MAX_SAMPLES);
    else if (samp_use_r < 9'd2)
      ns = NS_W'(2);
    else
      ns = NS_W'(samp_use_r);
  end

  assign in_acc      = in_valid && !in_stall;
  assign fi_in_range = 32'(in_feature_index) < 32'(nf);
  assign fi_last     = 32'(in_feature_index) == (32'(nf) - 32'd1);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r     <= 16'd655;
      iter_lim_r <= 16'd1000;
      thr_r      <= 16'd0;
      feat_use_r <= 4'd8;
      samp_use_r <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LEARNING_RATE:   rate_r     <= cfg_data;
        REG_ITERATION_LIMIT: iter_lim_r <= cfg_data;
        REG_STOP_THRESHOLD:  thr_r      <= cfg_data;
        REG_FEATURES_IN_USE: feat_use_r <= cfg_data[3:0];
        REG_SAMPLES_IN_USE:  samp_use_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // feature and target memories: one write port, one registered read port
  assign fwaddr  = AW'(AW'(in_sample_index) * AW'(MAX_FEATURES) + AW'(in_feature_index));
  assign fraddr  = AW'(AW'(scnt_r) * AW'(MAX_FEATURES) + AW'(jcnt_r));
  assign fmem_we = in_acc && (in_cmd == CMD_LOAD_FEATURE) &&
                   (32'(in_sample_index) < MAX_SAMPLES) &&
                   (32'(in_feature_index) < MAX_FEATURES);
  assign tmem_we = in_acc && (in_cmd == CMD_LOAD_TARGET) &&
                   (32'(in_sample_index) < MAX_SAMPLES);

  always_ff @(posedge clk) begin
    if (fmem_we)
      fmem[fwaddr] <= in_sample_value;
    fdat_r <= fmem[fraddr];
  end

  always_ff @(posedge clk) begin
    if (tmem_we)
      tmem[TAW'(in_sample_index)] <= in_sample_value;
    tdat_r <= tmem[TAW'(scnt_r)];
  end

  // shared divider
  lrgd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  // array reads and update arithmetic
  assign jidx     = FW'(jcnt_r);
  assign widx     = (state_r == S_P_MUL) ? p_fi_r : jidx;
  assign w_rd     = w_r[widx];
  assign gsel     = (jcnt_r == nf) ? bgrad_r : grad_r[jidx];
  assign cur_val  = (jcnt_r == nf) ? bias_r : w_r[jidx];
  assign prod_sh  = prod_r >>> 16;
  assign mul_full = mul_a * mul_b;
  assign psum_nxt = sat_add64((p_fi_r == '0) ? 64'(bias_r) : psum_r, prod_sh);
  assign upd_total = (prod_r <<< 24) + aux_r;
  assign upd_step  = upd_total >>> 16;
  assign upd_val   = sat32(65'(cur_val) - 65'(upd_step));
  assign stop_hit  = (prev_r != 64'd0) && ({diff_r, 16'd0} < rhs_r);

  // signed quotient, clipped to 48 bits
  always_comb begin
    if (gsel[63]) begin
      if (div_rsp.quotient >= 64'h0000_8000_0000_0000)
        g_sat = 48'sh8000_0000_0000;
      else
        g_sat = 48'(-div_rsp.quotient);
    end else begin
      if (div_rsp.quotient > 64'h0000_7FFF_FFFF_FFFF)
        g_sat = 48'sh7FFF_FFFF_FFFF;
      else
        g_sat = div_rsp.quotient[47:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_TRAIN)
            state_nxt = (iter_lim_r == 16'd0) ? S_T_FIN : S_T_PASS;
          else if ((in_cmd == CMD_PREDICT) && fi_in_range) begin
            if (trained_r)
              state_nxt = S_P_MUL;
            else if (fi_last)
              state_nxt = S_OUT;
          end
        end
      end
      S_P_MUL:  state_nxt = S_P_ACC;
      S_P_ACC:  state_nxt = (32'(p_fi_r) == 32'(nf) - 32'd1) ? S_OUT : S_IDLE;
      S_T_PASS: state_nxt = S_T_SAMP;
      S_T_SAMP: state_nxt = S_T_PRD;
      S_T_PRD:  state_nxt = S_T_PMUL;
      S_T_PMUL: state_nxt = S_T_PACC;
      S_T_PACC: state_nxt = (jcnt_r == nf - NFW'(1)) ? S_T_ERR : S_T_PRD;
      S_T_ERR:  state_nxt = S_T_GRD;
      S_T_GRD:  state_nxt = S_T_GMUL;
      S_T_GMUL: state_nxt = S_T_GACC;
      S_T_GACC: state_nxt = (jcnt_r == nf - NFW'(1)) ? S_T_SQ : S_T_GRD;
      S_T_SQ:   state_nxt = S_T_LOSS;
      S_T_LOSS: state_nxt = (scnt_r == ns - NS_W'(1)) ? S_T_CUR : S_T_SAMP;
      S_T_CUR:  state_nxt = S_T_CURW;
      S_T_CURW: state_nxt = div_rsp.done ? S_T_DIFF : S_T_CURW;
      S_T_DIFF: state_nxt = S_T_CMP1;
      S_T_CMP1: state_nxt = S_T_CMP2;
      S_T_CMP2: state_nxt = S_T_CMP3;
      S_T_CMP3: state_nxt = S_T_CMP4;
      S_T_CMP4: state_nxt = stop_hit ? S_T_FIN : S_T_UDIV;
      S_T_UDIV: state_nxt = S_T_UWAIT;
      S_T_UWAIT: state_nxt = div_rsp.done ? S_T_UM1 : S_T_UWAIT;
      S_T_UM1:  state_nxt = S_T_UM2;
      S_T_UM2:  state_nxt = S_T_UUPD;
      S_T_UUPD: begin
        if (jcnt_r != nf)
          state_nxt = S_T_UDIV;
        else if (it_r + 16'd1 == iter_lim_r)
          state_nxt = S_T_FIN;
        else
          state_nxt = S_T_PASS;
      end
      S_T_FIN:  state_nxt = S_OUT;
      S_OUT:    state_nxt = (!out_valid_r || !out_stall) ? S_IDLE : S_OUT;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control outputs: stall, multiplier operands, divider request
  always_comb begin
    in_stall         = (state_r != S_IDLE);
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = loss_r;
    div_req.divisor  = {1'b0, ns};
    case (state_r)
      S_P_MUL: begin
        mul_a = 33'(w_rd);
        mul_b = 33'(p_val_r);
      end
      S_T_PMUL: begin
        mul_a = 33'(w_rd);
        mul_b = 33'(fdat_r);
      end
      S_T_GMUL: begin
        mul_a = 33'(err_r);
        mul_b = 33'(fdat_r);
      end
      S_T_SQ: begin
        mul_a = 33'(err_r);
        mul_b = 33'(err_r);
      end
      S_T_CMP1: begin
        mul_a = {1'b0, prev_r[31:0]};
        mul_b = {17'd0, thr_r};
      end
      S_T_CMP2: begin
        mul_a = {1'b0, prev_r[63:32]};
        mul_b = {17'd0, thr_r};
      end
      S_T_UM1: begin
        mul_a = {9'd0, g_r[23:0]};
        mul_b = {17'd0, rate_r};
      end
      S_T_UM2: begin
        mul_a = {{9{g_r[47]}}, g_r[47:24]};
        mul_b = {17'd0, rate_r};
      end
      S_T_CUR: begin
        div_req.start    = 1'b1;
        div_req.dividend = loss_r;
        div_req.divisor  = {ns, 1'b0};
      end
      S_T_UDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = gsel[63] ? 64'(-gsel) : 64'(gsel);
        div_req.divisor  = {1'b0, ns};
      end
      default: ;
    endcase
  end

  // multiplier output register
  always_ff @(posedge clk) begin
    prod_r <= mul_full[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      trained_r   <= 1'b0;
      psum_r      <= '0;
      bias_r      <= '0;
      bgrad_r     <= '0;
      prev_r      <= '1;
      scnt_r      <= '0;
      jcnt_r      <= '0;
      it_r        <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_FEATURES; k++) begin
        w_r[k]    <= '0;
        grad_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      // drop the result once taken, unless a new one replaces it
      if (out_valid_r && !out_stall && (state_r != S_OUT))
        out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          p_fi_r  <= FW'(in_feature_index);
          p_val_r <= in_sample_value;
          pend_status_r <= STATUS_NOT_TRAINED;
          pend_pred_r   <= '0;
          pend_stop_r   <= '0;
          if (in_acc && (in_cmd == CMD_TRAIN)) begin
            trained_r <= 1'b0;
            prev_r    <= '1;
            it_r      <= '0;
          end
        end
        S_P_ACC: begin
          psum_r        <= psum_nxt;
          pend_status_r <= STATUS_PRED_READY;
          pend_pred_r   <= sat32(65'(psum_nxt));
          pend_stop_r   <= '0;
        end
        S_T_PASS: begin
          for (int k = 0; k < MAX_FEATURES; k++)
            grad_r[k] <= '0;
          bgrad_r <= '0;
          loss_r  <= '0;
          scnt_r  <= '0;
        end
        S_T_SAMP: begin
          yp_r   <= 64'(bias_r);
          jcnt_r <= '0;
        end
        S_T_PACC: begin
          yp_r   <= yp_r + prod_sh;
          jcnt_r <= (jcnt_r == nf - NFW'(1)) ? '0 : jcnt_r + NFW'(1);
        end
        S_T_ERR: err_r <= sat32(65'(yp_r) - 65'(tdat_r));
        S_T_GACC: begin
          grad_r[jidx] <= sat_add64(grad_r[jidx], prod_sh);
          jcnt_r <= jcnt_r + NFW'(1);
        end
        S_T_SQ: bgrad_r <= sat_add64(bgrad_r, 64'(err_r));
        S_T_LOSS: begin
          loss_r <= loss_r + {16'd0, prod_r[63:16]};
          if (scnt_r != ns - NS_W'(1))
            scnt_r <= scnt_r + NS_W'(1);
        end
        S_T_CURW: if (div_rsp.done) curr_r <= div_rsp.quotient;
        S_T_DIFF: diff_r <= (prev_r > curr_r) ? prev_r - curr_r : curr_r - prev_r;
        S_T_CMP2: aux_r <= prod_r;
        S_T_CMP3: rhs_r <= (80'(prod_r) << 32) + 80'(aux_r);
        S_T_CMP4: jcnt_r <= '0;
        S_T_UWAIT: if (div_rsp.done) g_r <= g_sat;
        S_T_UM2: aux_r <= prod_r;
        S_T_UUPD: begin
          if (jcnt_r == nf) begin
            bias_r <= upd_val;
            prev_r <= curr_r;
            it_r   <= it_r + 16'd1;
          end else begin
            w_r[jidx] <= upd_val;
            jcnt_r    <= jcnt_r + NFW'(1);
          end
        end
        S_T_FIN: begin
          // stop iteration is the pass index on early stop, else the limit
          trained_r     <= 1'b1;
          pend_status_r <= STATUS_TRAIN_DONE;
          pend_pred_r   <= '0;
          pend_stop_r   <= it_r;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r          <= 1'b1;
            out_status_r         <= pend_status_r;
            out_prediction_r     <= pend_pred_r;
            out_stop_iteration_r <= pend_stop_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_prediction     = out_prediction_r;
  assign out_stop_iteration = out_stop_iteration_r;

  `ASSERT_IMPLY(a_div_start_idle, clk, rst_n, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `ASSERT_IMPLY(a_div_done_waited, clk, rst_n, div_rsp.done, (state_r == S_T_CURW) || (state_r == S_T_UWAIT), "divider result not awaited")
  `ASSERT_IMPLY(a_sample_in_range, clk, rst_n, (state_r == S_T_PRD) || (state_r == S_T_GRD) || (state_r == S_T_LOSS), scnt_r < ns, "sample counter past sample count")
  `ASSERT_NEXT(a_train_sets_flag, clk, rst_n, state_r == S_T_FIN, trained_r && (pend_status_r == STATUS_TRAIN_DONE), "training finish lost")

endmodule

/* hw/rtl/lrgd_div.sv */
// Radix-2 restoring divider, unsigned 64-bit dividend by a narrow divisor.
module lrgd_div import lrgd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t div_req,
  output div_rsp_t div_rsp
);

  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dvs_r;
  logic [5:0]            cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_sub;
  logic                  fit;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIVIDEND_W-1]};
    fit     = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (div_req.start) begin
        quo_r  <= div_req.dividend;
        rem_r  <= '0;
        dvs_r  <= div_req.divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // shift one quotient bit in per cycle
        rem_r <= fit ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        quo_r <= {quo_r[DIVIDEND_W-2:0], fit};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign div_rsp.busy     = busy_r;
  assign div_rsp.done     = done_r;
  assign div_rsp.quotient = quo_r;

endmodule

/* bench/tb_linear_regression_gd_trainer_unit.sv */
// Testbench for the gradient descent linear regression trainer: directed and random words.
module tb_linear_regression_gd_trainer_unit import lrgd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFEAT_MAX = 8;
  localparam int NSAMP_MAX = 256;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] prediction;
    logic [15:0]        stop_iteration;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_cmd = CMD_LOAD_FEATURE;
  logic [7:0]            in_sample_index = '0;
  logic [2:0]            in_feature_index = '0;
  logic signed [31:0]    in_sample_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_status;
  logic signed [31:0]    out_prediction;
  logic [15:0]           out_stop_iteration;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_LEARNING_RATE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  linear_regression_gd_trainer_unit i_dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the trainer: stores, model and configuration.
  int                 feat_mem [NSAMP_MAX][NFEAT_MAX];
  int                 tgt_mem [NSAMP_MAX];
  bit                 feat_known [NSAMP_MAX][NFEAT_MAX];
  bit                 tgt_known [NSAMP_MAX];
  int                 weights [NFEAT_MAX];
  int                 bias;
  bit                 model_trained;
  longint             pred_acc;
  logic [15:0]        rate_q16 = 16'd655;
  logic [15:0]        pass_limit = 16'd1000;
  logic [15:0]        stop_thr = 16'd0;
  logic [3:0]         feat_count = 4'd8;
  logic [8:0]         samp_count = 9'd256;

  result_t            results_due[$];
  int                 mismatches;
  int                 hold_requests;
  int                 burst_left;
  bit                 gapless;

  function automatic int used_features();
    if (feat_count < 1) return 1;
    if (feat_count > NFEAT_MAX) return NFEAT_MAX;
    return feat_count;
  endfunction

  function automatic int used_samples();
    if (samp_count > NSAMP_MAX) return NSAMP_MAX;
    if (samp_count < 2) return 2;
    return samp_count;
  endfunction

  function automatic longint floor16(longint v);
    return v >>> 16;
  endfunction

  function automatic int clip32(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic longint add_clip64(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(s[63:0]);
  endfunction

  // Move one parameter against its averaged gradient.
  function automatic int descend(int v, longint grad_sum, int n);
    longint g;
    longint lim;
    lim = (64'sd1 <<< 47) - 1;
    g = grad_sum / longint'(n);
    if (g > lim) g = lim;
    if (g < -lim - 1) g = -lim - 1;
    return clip32(longint'(v) - floor16(longint'({48'd0, rate_q16}) * g));
  endfunction

  // Run the batch descent on the shadow model; return the stop pass.
  function automatic logic [15:0] run_training();
    int nf, ns, err;
    longint grads [NFEAT_MAX];
    longint bias_grad, yp;
    longint unsigned prev, loss, curr, diff;
    logic [127:0] lhs, rhs;
    logic [15:0] stop;
    nf = used_features();
    ns = used_samples();
    stop = pass_limit;
    prev = '1;
    for (int it = 0; it < pass_limit; it++) begin
      loss = 0;
      bias_grad = 0;
      foreach (grads[j]) grads[j] = 0;
      for (int i = 0; i < ns; i++) begin
        yp = bias;
        for (int j = 0; j < nf; j++)
          yp += floor16(longint'(weights[j]) * longint'(feat_mem[i][j]));
        err = clip32(yp - longint'(tgt_mem[i]));
        for (int j = 0; j < nf; j++)
          grads[j] = add_clip64(grads[j], floor16(longint'(err) * longint'(feat_mem[i][j])));
        bias_grad = add_clip64(bias_grad, err);
        loss += longint'(unsigned'(longint'(err) * longint'(err))) >> 16;
      end
      curr = loss / (2 * ns);
      diff = prev > curr ? prev - curr : curr - prev;
      lhs = {64'd0, diff} << 16;
      rhs = {64'd0, prev} * {112'd0, stop_thr};
      if (prev > 0 && lhs < rhs) begin
        stop = it[15:0];
        break;
      end
      for (int j = 0; j < nf; j++) weights[j] = descend(weights[j], grads[j], ns);
      bias = descend(bias, bias_grad, ns);
      prev = curr;
    end
    model_trained = 1'b1;
    return stop;
  endfunction

  // Apply one accepted word to the shadow model and queue its result, if any.
  function automatic void expect_word(logic [1:0] cmd, logic [7:0] si, logic [2:0] fi,
                                      logic signed [31:0] val);
    int nf;
    result_t r;
    case (cmd)
      CMD_LOAD_FEATURE: begin
        feat_mem[si][fi] = val;
        feat_known[si][fi] = 1'b1;
      end
      CMD_LOAD_TARGET: begin
        tgt_mem[si] = val;
        tgt_known[si] = 1'b1;
      end
      CMD_TRAIN: begin
        r.stop_iteration = run_training();
        r.status = STATUS_TRAIN_DONE;
        r.prediction = '0;
        results_due.push_back(r);
      end
      default: begin
        nf = used_features();
        if (fi < nf) begin
          if (model_trained) begin
            if (fi == 0) pred_acc = bias;
            pred_acc = add_clip64(pred_acc, floor16(longint'(weights[fi]) * longint'(val)));
          end
          if (fi == nf - 1) begin
            r.status = model_trained ? STATUS_PRED_READY : STATUS_NOT_TRAINED;
            r.prediction = model_trained ? clip32(pred_acc) : 0;
            r.stop_iteration = '0;
            results_due.push_back(r);
          end
        end
      end
    endcase
  endfunction

  function automatic void note_error(string what);
    mismatches++;
    if (mismatches <= 10) $display("%t mismatch: %s", $realtime, what);
  endfunction

  // Check each result word against the oldest expectation.
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        note_error($sformatf("unexpected word status %0d pred %0d stop %0d",
                             out_status, out_prediction, out_stop_iteration));
      end else begin
        e = results_due.pop_front();
        if (out_status !== e.status)
          note_error($sformatf("status exp %0d got %0d", e.status, out_status));
        if (out_prediction !== e.prediction)
          note_error($sformatf("prediction exp %0d got %0d", e.prediction, out_prediction));
        if (out_stop_iteration !== e.stop_iteration)
          note_error($sformatf("stop_iteration exp %0d got %0d",
                               e.stop_iteration, out_stop_iteration));
      end
    end
  end

  // Receiver: stall at a random rate that changes now and then; on request
  // hold off for a long stretch so the block fills up.
  int stall_pct = 0;
  int stall_phase = 0;
  int hold_left = 0;
  int holds_seen = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_requests != holds_seen) begin
      holds_seen <= hold_requests;
      hold_left <= 3000;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (stall_phase == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct <= 0;
          1: stall_pct <= 20;
          2: stall_pct <= 50;
          default: stall_pct <= 85;
        endcase
        stall_phase <= $urandom_range(30, 400);
      end else begin
        stall_phase <= stall_phase - 1;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Offer one word and hold it until taken.
  task automatic send_word(logic [1:0] cmd, logic [7:0] si, logic [2:0] fi,
                           logic signed [31:0] val);
    in_cmd <= cmd;
    in_sample_index <= si;
    in_feature_index <= fi;
    in_sample_value <= val;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expect_word(cmd, si, fi, val);
    // Sender bursts: drop valid for a random gap once a burst runs out.
    if (!gapless) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        burst_left = $urandom_range(0, 30);
      end
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3, 4: return $urandom;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  // Let the block drain before touching configuration.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LEARNING_RATE:   rate_q16 = data;
      REG_ITERATION_LIMIT: pass_limit = data;
      REG_STOP_THRESHOLD:  stop_thr = data;
      REG_FEATURES_IN_USE: feat_count = data[3:0];
      REG_SAMPLES_IN_USE:  samp_count = data[8:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_all(logic [15:0] lr, logic [15:0] iters, logic [15:0] thr,
                         logic [15:0] nf, logic [15:0] ns);
    wait_quiet();
    write_reg(REG_LEARNING_RATE, lr);
    write_reg(REG_ITERATION_LIMIT, iters);
    write_reg(REG_STOP_THRESHOLD, thr);
    write_reg(REG_FEATURES_IN_USE, nf);
    write_reg(REG_SAMPLES_IN_USE, ns);
  endtask

  // Load every feature and target training will read, then train.
  task automatic train_now();
    for (int i = 0; i < used_samples(); i++) begin
      for (int j = 0; j < used_features(); j++)
        if (!feat_known[i][j]) send_word(CMD_LOAD_FEATURE, 8'(i), 3'(j), pick_value());
      if (!tgt_known[i]) send_word(CMD_LOAD_TARGET, 8'(i), 3'd0, pick_value());
    end
    send_word(CMD_TRAIN, 8'($urandom), 3'($urandom), 32'($urandom));
  endtask

  task automatic predict_row(int upto);
    for (int j = 0; j <= upto; j++)
      send_word(CMD_PREDICT, 8'($urandom), 3'(j), pick_value());
  endtask

  // Predict before any training: only the last feature answers, as not trained.
  task automatic test_untrained();
    send_word(CMD_PREDICT, 8'd0, 3'd3, 32'sd0);
    predict_row(NFEAT_MAX - 1);
  endtask

  // Extreme load addresses and values.
  task automatic test_load_extremes();
    send_word(CMD_LOAD_FEATURE, 8'd255, 3'd7, 32'sh7FFF_FFFF);
    send_word(CMD_LOAD_FEATURE, 8'd0, 3'd0, 32'sh8000_0000);
    send_word(CMD_LOAD_FEATURE, 8'd1, 3'd0, -32'sd1);
    send_word(CMD_LOAD_TARGET, 8'd255, 3'd7, 32'sh8000_0000);
    send_word(CMD_LOAD_TARGET, 8'd0, 3'd0, 32'sh7FFF_FFFF);
  endtask

  // Zero passes still marks the model trained; clamps of both counts.
  task automatic test_zero_passes();
    set_all(16'hFFFF, 16'd0, 16'd0, 16'd15, 16'd0);
    train_now();
    predict_row(NFEAT_MAX - 1);
  endtask

  // A few real passes, then predicts including ignored feature slots.
  task automatic test_short_training();
    set_all(16'd655, 16'd5, 16'd0, 16'd3, 16'd4);
    train_now();
    predict_row(2);
    send_word(CMD_PREDICT, 8'd0, 3'd7, 32'sd5);
    send_word(CMD_PREDICT, 8'd0, 3'd2, 32'sh0001_0000);
    set_all(16'd0, 16'd3, 16'd0, 16'd0, 16'd2);
    train_now();
    predict_row(0);
  endtask

  // Frozen weights give a flat loss: a wide threshold stops at the second pass,
  // over every sample.
  task automatic test_early_stop();
    set_all(16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'd511);
    train_now();
    predict_row(NFEAT_MAX - 1);
  endtask

  // Unknown register indexes must leave everything as it was.
  task automatic test_unknown_regs();
    wait_quiet();
    write_reg(3'd5, 16'hFFFF);
    write_reg(3'd6, 16'h0000);
    write_reg(3'd7, 16'h5A5A);
    predict_row(NFEAT_MAX - 1);
  endtask

  // Long receiver hold-off with predicts streaming in back to back.
  task automatic test_backpressure();
    set_all(16'd300, 16'd2, 16'd0, 16'd2, 16'd3);
    train_now();
    gapless = 1'b1;
    hold_requests++;
    for (int k = 0; k < 40; k++) predict_row(1);
    gapless = 1'b0;
  endtask

  task automatic test_random(int total);
    int sent;
    int next_cfg;
    int r;
    sent = 0;
    next_cfg = 0;
    while (sent < total) begin
      if (sent >= next_cfg) begin
        set_all(16'($urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom_range(0, 4000)),
                16'($urandom_range(0, 6)),
                16'($urandom_range(0, 2) == 0 ? 16'd0 : $urandom),
                16'($urandom_range(0, 15)),
                16'($urandom_range(0, 10)));
        next_cfg = sent + $urandom_range(150, 350);
        burst_left = 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
        predict_row(used_features() - 1);
        sent += used_features();
      end else if (r < 72) begin
        send_word(CMD_LOAD_FEATURE, 8'($urandom), 3'($urandom), pick_value());
        sent++;
      end else if (r < 82) begin
        send_word(CMD_LOAD_TARGET, 8'($urandom), 3'($urandom), pick_value());
        sent++;
      end else if (r < 85) begin
        train_now();
        sent++;
      end else if (r < 93) begin
        send_word(CMD_PREDICT, 8'($urandom), 3'($urandom), pick_value());
        sent++;
      end else begin
        // Broken row: stop short of the last feature.
        r = $urandom_range(0, used_features() - 1);
        predict_row(r);
        sent += r + 1;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_untrained();
    test_load_extremes();
    test_zero_passes();
    test_short_training();
    test_unknown_regs();
    test_early_stop();
    test_backpressure();
    test_random(1170);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb_linear_regression_gd_trainer_unit: clean");
    end else begin
      $display("tb_linear_regression_gd_trainer_unit: errors");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #60_000_000;
    $display("tb_linear_regression_gd_trainer_unit: errors");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/lrgd_pkg.sv
hw/rtl/lrgd_div.sv
hw/rtl/linear_regression_gd_trainer_unit.sv
bench/tb_linear_regression_gd_trainer_unit.sv
